// ===== design/acbc_pkg.sv =====
// Package for the AES-128 CBC decryption block: types, byte tables and round
// functions shared by the controller, key expansion unit and datapath.
// No dependencies.
package acbc_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;

  typedef logic [127:0] block_t;
  typedef logic [RoundW-1:0] round_t;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   last_round;
    round_t round;
  } dp_cmd_t;

  typedef struct packed {
    logic   start;
    logic   step;
    round_t round;
  } kx_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] t;
    p = 8'h00;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ t;
      t = xtime(t);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] x, input int unsigned n);
    rot8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_f(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_f = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_f(input logic [7:0] x);
    inv_sbox_f = gf_inv(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_tbl_t [256];

  function automatic sbox_tbl_t make_sbox(input logic inv);
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_f(8'(i)) : sbox_f(8'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_tbl_t Sbox    = make_sbox(1'b0);
  localparam sbox_tbl_t InvSbox = make_sbox(1'b1);

  // Byte i of a block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] byte_of(input block_t s, input int unsigned i);
    byte_of = s[127 - 8 * i -: 8];
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = InvSbox[byte_of(s, r + 4 * c)];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t inv_mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, 4 * c);
      a1 = byte_of(s, 4 * c + 1);
      a2 = byte_of(s, 4 * c + 2);
      a3 = byte_of(s, 4 * c + 3);
      t[127 - 32 * c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^
                             gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
      t[119 - 32 * c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^
                             gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
      t[111 - 32 * c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^
                             gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
      t[103 - 32 * c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^
                             gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
    end
    inv_mix_columns = t;
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rcon, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== design/acbc_keyexp.sv =====
// Round key store and expansion unit: one forward round key a cycle into a
// small key memory, read at one address chosen by the controller.
// Depends on acbc_pkg.
module acbc_keyexp import acbc_pkg::*; (
  input  logic    clk,
  input  kx_cmd_t cmd,
  input  block_t  key,
  input  round_t  rd_round,
  output block_t  rd_key
);

  block_t     key_mem [NumRounds + 1];
  block_t     cur_r;
  logic [7:0] rcon_r;
  block_t     nxt_key;

  assign nxt_key = next_round_key(cur_r, rcon_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_r <= key;
      rcon_r <= 8'h01;
      key_mem[0] <= key;
    end else if (cmd.step) begin
      cur_r <= nxt_key;
      rcon_r <= xtime(rcon_r);
      key_mem[cmd.round] <= nxt_key;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_round];
  end

endmodule

// ===== design/acbc_datapath.sv =====
// Datapath: inverse round state register, chain value and output register.
// Round keys come from the key unit; commands come from the controller.
// Depends on acbc_pkg.
module acbc_datapath import acbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  logic    iv_wr,
  input  logic    cipher_wr,
  input  logic    out_wr,
  input  block_t  in_block,
  input  logic    in_final,
  input  block_t  round_key,
  output block_t  plain,
  output logic    last,
  output logic [7:0] pad
);

  block_t state_r;
  block_t cipher_r;
  block_t chain_r;
  logic   final_r;
  block_t round_out;
  block_t plain_nxt;

  always_comb begin
    round_out = inv_shift_sub(state_r) ^ round_key;
    if (!cmd.last_round) round_out = inv_mix_columns(round_out);
  end

  assign plain_nxt = round_out ^ chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (iv_wr) begin
      chain_r <= in_block;
    end else if (out_wr) begin
      chain_r <= cipher_r;
    end
    if (cipher_wr) begin
      cipher_r <= in_block;
      final_r <= in_final;
    end
    if (cmd.load) begin
      state_r <= cipher_r ^ round_key;
    end else if (cmd.step) begin
      state_r <= round_out;
    end
    if (out_wr) begin
      plain <= plain_nxt;
      last <= final_r;
      pad <= final_r ? plain_nxt[7:0] : 8'h00;
    end
  end

endmodule

// ===== design/acbc_ctrl.sv =====
// Controller state machine: key expansion after reset or key write, then
// a load step (ST_FETCH) and the inverse rounds (ST_ROUND) per ciphertext word.
// Depends on acbc_pkg.
module acbc_ctrl import acbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    key_wr,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output kx_cmd_t kx_cmd,
  output round_t  key_round,
  output dp_cmd_t dp_cmd,
  output logic    iv_wr,
  output logic    cipher_wr,
  output logic    out_wr
);

  typedef enum logic [2:0] {
    ST_KSTART, ST_KEXP, ST_IDLE, ST_FETCH, ST_ROUND
  } state_t;

  state_t state_r;
  round_t cnt_r;
  logic   out_valid_r;
  logic   accept;
  logic   busy_out;

  assign busy_out  = out_valid_r && out_stall;
  assign in_stall  = (state_r != ST_IDLE) || key_wr || busy_out;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign iv_wr     = accept && !in_kind;
  assign cipher_wr = accept && in_kind;

  assign kx_cmd.start = (state_r == ST_KSTART);
  assign kx_cmd.step  = (state_r == ST_KEXP);
  assign kx_cmd.round = cnt_r;

  // Key read address is set for the round the datapath runs next, to cover the registered read.
  always_comb begin
    unique case (state_r)
      ST_IDLE:  key_round = round_t'(NumRounds);
      ST_FETCH: key_round = round_t'(NumRounds - 1);
      ST_ROUND: key_round = cnt_r - round_t'(2);
      default:  key_round = '0;
    endcase
  end

  assign dp_cmd.load       = (state_r == ST_FETCH);
  assign dp_cmd.step       = (state_r == ST_ROUND);
  assign dp_cmd.last_round = (cnt_r == round_t'(1));
  assign dp_cmd.round      = cnt_r;
  assign out_wr            = (state_r == ST_ROUND) && (cnt_r == round_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KSTART;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (key_wr) begin
        state_r <= ST_KSTART;
      end else begin
        unique case (state_r)
          ST_KSTART: begin
            state_r <= ST_KEXP;
            cnt_r <= round_t'(1);
          end
          ST_KEXP: begin
            cnt_r <= cnt_r + round_t'(1);
            if (cnt_r == round_t'(NumRounds)) state_r <= ST_IDLE;
          end
          ST_IDLE: begin
            if (accept && in_kind) state_r <= ST_FETCH;
          end
          ST_FETCH: begin
            state_r <= ST_ROUND;
            cnt_r <= round_t'(NumRounds);
          end
          ST_ROUND: begin
            cnt_r <= cnt_r - round_t'(1);
            if (cnt_r == round_t'(1)) state_r <= ST_IDLE;
          end
          default: state_r <= ST_KSTART;
        endcase
      end
    end
  end

  a_out_only_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |=> out_valid_r) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !accept) else $error("word taken while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (cnt_r != '0)) else $error("bad round count");
  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> $past(state_r) == ST_IDLE) else $error("bad fetch entry");

endmodule

// ===== design/aes_cbc_decrypt.sv =====
// AES-128 CBC decryption top level: APB key registers, controller, key
// expansion unit and datapath.
// Depends on acbc_pkg, acbc_ctrl, acbc_keyexp and acbc_datapath.
//
// A ciphertext word is captured when accepted and its result is presented after
// one load step and ten inverse rounds through one shared round unit, reading one
// stored round key per cycle. No further word is accepted until the last round
// of the current word is done. An IV word gives no result. A result held by a
// stalled receiver stalls the input. After reset and after every key write the
// block expands the round keys and takes no word meanwhile.
module aes_cbc_decrypt import acbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_final_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low,
  output logic        out_last,
  output logic [7:0]  out_pad_count
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic        wr;
  logic        key_wr;
  logic [1:0]  reg_idx;
  kx_cmd_t     kx_cmd;
  dp_cmd_t     dp_cmd;
  round_t      key_round;
  block_t      round_key;
  block_t      plain;
  logic        iv_wr;
  logic        cipher_wr;
  logic        out_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3] ? RegKeyLow : RegKeyHigh;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign key_wr     = wr && (cfg_paddr[2:0] == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else if (key_wr) begin
      unique case (reg_idx)
        RegKeyHigh: key_high_r <= cfg_pwdata;
        RegKeyLow:  key_low_r <= cfg_pwdata;
        default:    key_low_r <= key_low_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegKeyHigh: cfg_prdata = key_high_r;
      RegKeyLow:  cfg_prdata = key_low_r;
      default:    cfg_prdata = '0;
    endcase
  end

  acbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .key_wr(key_wr), .in_valid(in_valid),
    .in_kind(in_kind), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .kx_cmd(kx_cmd), .key_round(key_round),
    .dp_cmd(dp_cmd), .iv_wr(iv_wr), .cipher_wr(cipher_wr), .out_wr(out_wr)
  );

  acbc_keyexp u_keyexp (
    .clk(clk), .cmd(kx_cmd), .key({key_high_r, key_low_r}),
    .rd_round(key_round), .rd_key(round_key)
  );

  acbc_datapath u_datapath (
    .clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .iv_wr(iv_wr), .cipher_wr(cipher_wr),
    .out_wr(out_wr), .in_block({in_block_high, in_block_low}),
    .in_final(in_final_block), .round_key(round_key), .plain(plain),
    .last(out_last), .pad(out_pad_count)
  );

  assign out_plain_high = plain[127:64];
  assign out_plain_low  = plain[63:0];

endmodule

// ===== verif/aes_cbc_decrypt_test.sv =====
// Testbench for aes_cbc_decrypt: drives IV and ciphertext words, writes the key
// over the APB port and checks each plaintext word against a built-in predictor.
// Depends on acbc_pkg and the aes_cbc_decrypt RTL.
`timescale 1ns / 100ps

module aes_cbc_decrypt_test;
  import acbc_pkg::*;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        last;
    logic [7:0]  pad_count;
  } plain_word_t;

  localparam logic KindIv     = 1'b0;
  localparam logic KindCipher = 1'b1;
  localparam int   IdleLimit  = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [63:0] in_block_high = '0, in_block_low = '0;
  logic        in_final_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_plain_high, out_plain_low;
  logic        out_last;
  logic [7:0]  out_pad_count;

  aes_cbc_decrypt DUT (.*);

  always #5 clk = ~clk;

  logic [7:0]  inv_tbl [256];
  logic [7:0]  fwd_tbl [256];
  logic [127:0] key_sched [11];
  logic [63:0] key_hi_m = '0, key_lo_m = '0;
  logic [127:0] chain_m = '0;
  plain_word_t plain_queue[$];
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          idle_cycles = 0;
  bit          failed = 1'b0;

  function automatic logic [7:0] mul_gf(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  task automatic build_tables();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      b = 8'(x);
      for (int e = 254; e != 0; e >>= 1) begin
        if (e & 1) inv = mul_gf(inv, b);
        b = mul_gf(b, b);
      end
      fwd_tbl[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_tbl[fwd_tbl[x]] = 8'(x);
  endtask

  task automatic expand_model_key();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    w[0] = key_hi_m[63:32]; w[1] = key_hi_m[31:0];
    w[2] = key_lo_m[63:32]; w[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_tbl[t[23:16]] ^ rc, fwd_tbl[t[15:8]], fwd_tbl[t[7:0]], fwd_tbl[t[31:24]]};
        rc = mul_gf(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) key_sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [7:0] sbyte(logic [127:0] s, int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] unshift_unsub(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = inv_tbl[sbyte(s, r + 4*c)];
    return t;
  endfunction

  function automatic logic [127:0] unmix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sbyte(s, 4*c); a1 = sbyte(s, 4*c+1); a2 = sbyte(s, 4*c+2); a3 = sbyte(s, 4*c+3);
      t[127-32*c -: 8] = mul_gf(a0, 8'd14) ^ mul_gf(a1, 8'd11) ^
                         mul_gf(a2, 8'd13) ^ mul_gf(a3, 8'd9);
      t[119-32*c -: 8] = mul_gf(a0, 8'd9) ^ mul_gf(a1, 8'd14) ^
                         mul_gf(a2, 8'd11) ^ mul_gf(a3, 8'd13);
      t[111-32*c -: 8] = mul_gf(a0, 8'd13) ^ mul_gf(a1, 8'd9) ^
                         mul_gf(a2, 8'd14) ^ mul_gf(a3, 8'd11);
      t[103-32*c -: 8] = mul_gf(a0, 8'd11) ^ mul_gf(a1, 8'd13) ^
                         mul_gf(a2, 8'd9) ^ mul_gf(a3, 8'd14);
    end
    return t;
  endfunction

  task automatic predict_plain(logic kind, logic [127:0] blk, logic fin);
    logic [127:0] s;
    plain_word_t  w;
    if (kind == KindIv) begin
      chain_m = blk;
      return;
    end
    s = blk ^ key_sched[10];
    for (int r = 9; r >= 1; r--) s = unmix(unshift_unsub(s) ^ key_sched[r]);
    s = unshift_unsub(s) ^ key_sched[0] ^ chain_m;
    chain_m = blk;
    w.plain_high = s[127:64];
    w.plain_low = s[63:0];
    w.last = fin;
    w.pad_count = fin ? s[7:0] : 8'h00;
    plain_queue.push_back(w);
  endtask

  task automatic write_key(logic [3:0] addr, logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == 4'h0) key_hi_m = value;
    else key_lo_m = value;
    expand_model_key();
  endtask

  task automatic drain();
    while (plain_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    drain();
    write_key(4'h0, hi);
    write_key(4'h8, lo);
  endtask

  task automatic send_word(logic kind, logic [63:0] hi, logic [63:0] lo, logic fin);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    @(posedge clk);
    in_valid <= 1'b1;
    in_kind <= kind; in_block_high <= hi; in_block_low <= lo; in_final_block <= fin;
    do @(posedge clk); while (in_stall);
    predict_plain(kind, {hi, lo}, fin);
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(int nblocks);
    send_word(KindIv, rnd64(), rnd64(), 1'($urandom));
    for (int i = 0; i < nblocks; i++)
      send_word(KindCipher, rnd64(), rnd64(), i == nblocks - 1);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    plain_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (plain_queue.size() == 0) begin
        $display("%0t: unexpected word %h %h", $time, out_plain_high, out_plain_low);
        failed = 1'b1;
      end else begin
        e = plain_queue.pop_front();
        if (out_plain_high !== e.plain_high || out_plain_low !== e.plain_low ||
            out_last !== e.last || out_pad_count !== e.pad_count) begin
          $display("%0t: expected %h %h %b %h, got %h %h %b %h", $time,
                   e.plain_high, e.plain_low, e.last, e.pad_count,
                   out_plain_high, out_plain_low, out_last, out_pad_count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_word(KindIv, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1);
    send_word(KindCipher, 64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b0);
    send_word(KindCipher, 64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b1);
    send_word(KindCipher, '1, '1, 1'b1);
    send_word(KindCipher, '0, '0, 1'b0);
    send_word(KindIv, '1, '1, 1'b0);
    send_word(KindCipher, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
    load_key('1, '1);
    send_word(KindCipher, '0, '1, 1'b1);
    send_word(KindIv, '0, '0, 1'b1);
    send_word(KindCipher, '1, '0, 1'b0);
    load_key('0, '0);
    send_word(KindCipher, rnd64(), rnd64(), 1'b1);
  endtask

  task automatic test_random(int words);
    int sent;
    int n;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(9) == 0) begin
        send_word(1'($urandom), rnd64(), rnd64(), 1'($urandom));
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        send_message(n);
        sent += n + 1;
      end
    end
  endtask

  task automatic test_idle_phases();
    int send_pct [4] = '{0, 59, 0, 25};
    int recv_pct [4] = '{0, 0, 59, 25};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      load_key(rnd64(), rnd64());
      test_random(300);
      drain();
      test_random(80);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  initial begin
    build_tables();
    expand_model_key();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idle_phases();
    test_random(60);
    drain();
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/acbc_pkg.sv
design/acbc_keyexp.sv
design/acbc_datapath.sv
design/acbc_ctrl.sv
design/aes_cbc_decrypt.sv
verif/aes_cbc_decrypt_test.sv
